// ----- rtl/core/sfcdr_pkg.sv -----
// shared types and constants for the spi flash chunked dump reader
package sfcdr_pkg;

    // sequencer phase, one-hot
    typedef enum logic [4:0] {
        PH_CMD   = 5'b00001,
        PH_ADDR  = 5'b00010,
        PH_DATA  = 5'b00100,
        PH_READY = 5'b01000,
        PH_DONE  = 5'b10000
    } phase_t;

    // status codes seen by the host
    localparam logic [1:0] ST_FILLING = 2'd0;
    localparam logic [1:0] ST_READY   = 2'd1;
    localparam logic [1:0] ST_DONE    = 2'd2;

    // request codes
    localparam logic REQ_TICK  = 1'b0;
    localparam logic REQ_CLEAR = 1'b1;

    // register indexes (paddr bit 2)
    localparam logic REG_FLASH_END = 1'b0;
    localparam logic REG_CHUNK_LEN = 1'b1;

    localparam logic [7:0]  READ_OPCODE   = 8'h03;
    localparam logic [24:0] FLASH_END_RST = 25'h100000;
    localparam logic [12:0] CHUNK_LEN_RST = 13'd2048;

    typedef struct packed {
        logic [24:0] flash_end;
        logic [12:0] chunk_len;
    } cfg_t;

    typedef struct packed {
        logic        cs_n;
        logic        mosi;
        logic        sck_pulse;
        logic        byte_valid;
        logic [7:0]  rx_byte;
        logic [11:0] byte_offset;
        logic [23:0] chunk_base;
        logic [1:0]  status;
    } result_t;

endpackage

// ----- rtl/core/sfcdr_regs.sv -----
// apb configuration registers: flash end and chunk length
module sfcdr_regs (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output sfcdr_pkg::cfg_t    cfg
);
    import sfcdr_pkg::*;

    logic [24:0] flash_end_reg;
    logic [12:0] chunk_len_reg;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flash_end_reg <= FLASH_END_RST;
            chunk_len_reg <= CHUNK_LEN_RST;
        end
        else if (wr_en)
        begin
            case (paddr[2])
                REG_FLASH_END: flash_end_reg <= pwdata[24:0];
                REG_CHUNK_LEN: chunk_len_reg <= pwdata[12:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_FLASH_END: prdata = {7'd0, flash_end_reg};
            REG_CHUNK_LEN: prdata = {19'd0, chunk_len_reg};
            default:       prdata = 32'd0;
        endcase
    end

    assign cfg.flash_end = flash_end_reg;
    assign cfg.chunk_len = chunk_len_reg;

endmodule

// ----- rtl/core/sfcdr_seq.sv -----
// read sequencer: phase and counters, at most one bus bit per tick item
module sfcdr_seq #(
    parameter int ADDR_BITS       = 24,
    parameter int MAX_CHUNK_BYTES = 4096
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic                req_type,
    input  logic                miso_bit,
    input  sfcdr_pkg::cfg_t     cfg,
    output sfcdr_pkg::result_t  res
);
    import sfcdr_pkg::*;

    localparam int BC_W   = $clog2(ADDR_BITS);
    localparam int AX_W   = 2 ** BC_W;
    localparam int BYTE_W = $clog2(MAX_CHUNK_BYTES + 1);

    phase_t            phase_reg, phase_next;
    logic [BC_W-1:0]   bit_cnt_reg, bit_cnt_next;
    logic [BYTE_W-1:0] byte_cnt_reg, byte_cnt_next;
    logic [23:0]       addr_reg, addr_next;
    logic [7:0]        rx_shift_reg, rx_shift_next;

    logic [31:0]       len_wide;
    logic [BYTE_W-1:0] eff_len;
    logic [24:0]       sum_addr;
    logic [BC_W-1:0]   addr_idx;
    logic [AX_W-1:0]   addr_ext;
    logic [BYTE_W-1:0] byte_cnt_inc;

    // chunk length saturated into 1..max
    assign len_wide = {19'd0, cfg.chunk_len};
    always_comb
    begin
        if (len_wide == 32'd0)
            eff_len = BYTE_W'(1);
        else if (len_wide > 32'(MAX_CHUNK_BYTES))
            eff_len = BYTE_W'(MAX_CHUNK_BYTES);
        else
            eff_len = BYTE_W'(len_wide);
    end

    assign sum_addr     = {1'b0, addr_reg} + 25'(eff_len);
    assign addr_idx     = BC_W'(ADDR_BITS - 1) - bit_cnt_reg;
    assign addr_ext     = AX_W'(addr_reg);
    assign byte_cnt_inc = byte_cnt_reg + BYTE_W'(1);

    always_comb
    begin
        phase_next    = phase_reg;
        bit_cnt_next  = bit_cnt_reg;
        byte_cnt_next = byte_cnt_reg;
        addr_next     = addr_reg;
        rx_shift_next = rx_shift_reg;
        res.cs_n        = 1'b1;
        res.mosi        = 1'b0;
        res.sck_pulse   = 1'b0;
        res.byte_valid  = 1'b0;
        res.rx_byte     = 8'd0;
        res.byte_offset = 12'd0;

        if (req_type == REQ_CLEAR)
        begin
            if (phase_reg == PH_READY)
            begin
                if (sum_addr >= cfg.flash_end || sum_addr[24])
                    phase_next = PH_DONE;
                else
                begin
                    addr_next     = sum_addr[23:0];
                    phase_next    = PH_CMD;
                    bit_cnt_next  = '0;
                    byte_cnt_next = '0;
                end
            end
        end
        else if (phase_reg == PH_CMD && bit_cnt_reg == '0
                 && {1'b0, addr_reg} >= cfg.flash_end)
        begin
            phase_next = PH_DONE;
        end
        else
        begin
            case (phase_reg)
                PH_CMD:
                begin
                    res.cs_n      = 1'b0;
                    res.sck_pulse = 1'b1;
                    res.mosi      = READ_OPCODE[~bit_cnt_reg[2:0]];
                    if (bit_cnt_reg >= BC_W'(7))
                    begin
                        phase_next   = PH_ADDR;
                        bit_cnt_next = '0;
                    end
                    else
                        bit_cnt_next = bit_cnt_reg + BC_W'(1);
                end
                PH_ADDR:
                begin
                    res.cs_n      = 1'b0;
                    res.sck_pulse = 1'b1;
                    // bits above the 24-bit address go out as zero
                    res.mosi      = addr_ext[addr_idx];
                    if (bit_cnt_reg >= BC_W'(ADDR_BITS - 1))
                    begin
                        phase_next    = PH_DATA;
                        bit_cnt_next  = '0;
                        byte_cnt_next = '0;
                        rx_shift_next = 8'd0;
                    end
                    else
                        bit_cnt_next = bit_cnt_reg + BC_W'(1);
                end
                PH_DATA:
                begin
                    res.cs_n      = 1'b0;
                    res.sck_pulse = 1'b1;
                    res.mosi      = 1'b1;
                    rx_shift_next = {rx_shift_reg[6:0], miso_bit};
                    if (bit_cnt_reg >= BC_W'(7))
                    begin
                        res.byte_valid  = 1'b1;
                        res.rx_byte     = rx_shift_next;
                        res.byte_offset = 12'(byte_cnt_reg);
                        bit_cnt_next    = '0;
                        byte_cnt_next   = byte_cnt_inc;
                        if (byte_cnt_inc >= eff_len)
                            phase_next = PH_READY;
                    end
                    else
                        bit_cnt_next = bit_cnt_reg + BC_W'(1);
                end
                default: ;
            endcase
        end

        res.chunk_base = addr_next;
        case (phase_next)
            PH_READY: res.status = ST_READY;
            PH_DONE:  res.status = ST_DONE;
            default:  res.status = ST_FILLING;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_CMD;
            bit_cnt_reg  <= '0;
            byte_cnt_reg <= '0;
            addr_reg     <= 24'd0;
            rx_shift_reg <= 8'd0;
        end
        else if (accept)
        begin
            phase_reg    <= phase_next;
            bit_cnt_reg  <= bit_cnt_next;
            byte_cnt_reg <= byte_cnt_next;
            addr_reg     <= addr_next;
            rx_shift_reg <= rx_shift_next;
        end
    end

endmodule

// ----- rtl/core/spi_flash_chunked_dump_reader.sv -----
// top level of the spi flash chunked dump reader: handshake, result register, checks
//
// Mode-0 SPI read sequencer that dumps a serial flash with the 0x03 read
// command, one chunk at a time. Each input item is either a bit tick
// (req_type 0) or a host clear (req_type 1); each item gives exactly one
// result item carrying chip select, the MOSI bit, an sck pulse flag, any
// completed data byte with its offset in the chunk, the chunk start address
// and the status after the item. One item is taken every clock cycle while in_valid
// is high and in_stall is low, and its result is in the result register in the
// next cycle; the rate is set by that single register stage, and input stall rises
// only while a result is held there under output stall. chunk_len is saturated
// into 1..MAX_CHUNK_BYTES where it is used; configuration is written over the APB
// port (flash_end at 0x0, chunk_len at 0x4); the user must write it only while the
// block is idle; the block does not enforce it. There is no clearing pass after reset.
module spi_flash_chunked_dump_reader #(
    parameter int ADDR_BITS       = 24,
    parameter int MAX_CHUNK_BYTES = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        req_type,
    input  logic        miso_bit,
    // output channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic        cs_n,
    output logic        mosi,
    output logic        sck_pulse,
    output logic        byte_valid,
    output logic [7:0]  rx_byte,
    output logic [11:0] byte_offset,
    output logic [23:0] chunk_base,
    output logic [1:0]  status
);
    import sfcdr_pkg::*;

    cfg_t    cfg;
    result_t res;
    result_t res_reg;
    logic    out_valid_reg;
    logic    accept;

    // stall only while a finished result is still waiting to be taken
    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;

    sfcdr_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    sfcdr_seq #(
        .ADDR_BITS       (ADDR_BITS),
        .MAX_CHUNK_BYTES (MAX_CHUNK_BYTES)
    ) u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .req_type (req_type),
        .miso_bit (miso_bit),
        .cfg      (cfg),
        .res      (res)
    );

    // result register: valid flag under reset, payload without
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            res_reg <= res;
    end

    assign out_valid   = out_valid_reg;
    assign cs_n        = res_reg.cs_n;
    assign mosi        = res_reg.mosi;
    assign sck_pulse   = res_reg.sck_pulse;
    assign byte_valid  = res_reg.byte_valid;
    assign rx_byte     = res_reg.rx_byte;
    assign byte_offset = res_reg.byte_offset;
    assign chunk_base  = res_reg.chunk_base;
    assign status      = res_reg.status;

    // an accepted item always leaves a result behind
    a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> out_valid)
        else $error("accepted item left no result");

    // input side only stalls behind a waiting result
    a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with no result pending");

    // a clocked bit always has chip select asserted
    a_sck_with_cs: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && sck_pulse) |-> !cs_n)
        else $error("bit clocked with chip select high");

    // a data byte only completes on a clocked data bit
    a_byte_on_data_bit: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && byte_valid) |-> (sck_pulse && mosi && status != ST_DONE))
        else $error("byte completed outside a data bit");

endmodule

// ----- sim/tb_spi_flash_chunked_dump_reader.sv -----
// testbench for the spi flash chunked dump reader: directed table, random chunks, self-checking
`timescale 1ns / 1ps

module tb_spi_flash_chunked_dump_reader;

    import sfcdr_pkg::*;

    // run limits
    localparam int CYCLE_LIMIT   = 400000;
    localparam int ERR_SHOW      = 10;
    localparam int RAND_PHASES   = 8;
    localparam int PHASE_ITEMS   = 28;
    localparam int LONG_HOLD     = 90;
    localparam int MAX_CHUNK     = 4096;
    localparam int ADDR_SPAN     = 32'h1000000;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_stall;
    logic        req_type;
    logic        miso_bit;
    logic        out_valid;
    logic        out_stall;
    logic        cs_n;
    logic        mosi;
    logic        sck_pulse;
    logic        byte_valid;
    logic [7:0]  rx_byte;
    logic [11:0] byte_offset;
    logic [23:0] chunk_base;
    logic [1:0]  status;

    spi_flash_chunked_dump_reader dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .req_type    (req_type),
        .miso_bit    (miso_bit),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .cs_n        (cs_n),
        .mosi        (mosi),
        .sck_pulse   (sck_pulse),
        .byte_valid  (byte_valid),
        .rx_byte     (rx_byte),
        .byte_offset (byte_offset),
        .chunk_base  (chunk_base),
        .status      (status)
    );

    // 20 ns clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // sequencer shadow: our own copy of the bus state and the registers
    // ------------------------------------------------------------------
    phase_t      seq_phase;
    logic [4:0]  bit_cnt;
    int          byte_cnt;        // kept wider than 12 bits so a 4096 byte chunk can end
    logic [23:0] cur_addr;
    logic [7:0]  rx_sr;
    logic [24:0] cfg_flash_end;
    logic [12:0] cfg_chunk_len;

    // results still owed by the block, oldest first
    result_t     pending_results[$];

    // bookkeeping
    int          cycle_cnt = 0;
    int          mismatches = 0;
    int          items_sent = 0;
    int          results_seen = 0;
    int          bytes_seen = 0;
    int          chunks_seen = 0;
    int          reg_writes = 0;
    bit          idling_on = 1'b1;
    int          hold_cycles = 0;

    // directed stimulus table
    typedef enum logic [1:0] {ROW_ITEM, ROW_WRITE} row_kind_t;

    typedef struct {
        row_kind_t   kind;
        logic        rq;
        logic        mb;
        int          reps;
        bit          typed;
        result_t     want;
        logic [2:0]  waddr;
        logic [31:0] wdata;
    } stim_row_t;

    stim_row_t   plan[$];

    // bytes per chunk as the block uses it, clamped into 1..4096
    function automatic int chunk_bytes();
        int n;
        n = int'(cfg_chunk_len);
        if (n < 1)
        begin
            n = 1;
        end
        if (n > MAX_CHUNK)
        begin
            n = MAX_CHUNK;
        end
        return n;
    endfunction

    function automatic void reset_sequencer();
        seq_phase     = PH_CMD;
        bit_cnt       = '0;
        byte_cnt      = 0;
        cur_addr      = '0;
        rx_sr         = '0;
        cfg_flash_end = FLASH_END_RST;
        cfg_chunk_len = CHUNK_LEN_RST;
    endfunction

    // one item through the shadow sequencer; returns the result it should give
    function automatic result_t step_sequencer(input logic rq, input logic mb);
        result_t r;
        int      nxt;
        r      = '0;
        r.cs_n = 1'b1;
        if (rq == REQ_CLEAR)
        begin
            // a clear only counts while a chunk is waiting for the host
            if (seq_phase == PH_READY)
            begin
                nxt = int'(cur_addr) + chunk_bytes();
                if (nxt >= int'(cfg_flash_end) || nxt >= ADDR_SPAN)
                begin
                    seq_phase = PH_DONE;
                end
                else
                begin
                    cur_addr  = nxt[23:0];
                    seq_phase = PH_CMD;
                    bit_cnt   = '0;
                    byte_cnt  = 0;
                end
            end
        end
        else if (seq_phase == PH_CMD && bit_cnt == 0 && cur_addr >= cfg_flash_end)
        begin
            // chunk would start at or past the end: give up without clocking
            seq_phase = PH_DONE;
        end
        else if (seq_phase == PH_CMD || seq_phase == PH_ADDR || seq_phase == PH_DATA)
        begin
            r.cs_n      = 1'b0;
            r.sck_pulse = 1'b1;
            if (seq_phase == PH_CMD)
            begin
                r.mosi = READ_OPCODE[3'd7 - bit_cnt[2:0]];
                if (bit_cnt >= 5'd7)
                begin
                    seq_phase = PH_ADDR;
                    bit_cnt   = '0;
                end
                else
                begin
                    bit_cnt = bit_cnt + 5'd1;
                end
            end
            else if (seq_phase == PH_ADDR)
            begin
                r.mosi = cur_addr[5'd23 - bit_cnt];
                if (bit_cnt >= 5'd23)
                begin
                    seq_phase = PH_DATA;
                    bit_cnt   = '0;
                    byte_cnt  = 0;
                    rx_sr     = '0;
                end
                else
                begin
                    bit_cnt = bit_cnt + 5'd1;
                end
            end
            else
            begin
                // data phase: mosi idles high, miso shifts in msb first
                r.mosi = 1'b1;
                rx_sr  = {rx_sr[6:0], mb};
                if (bit_cnt >= 5'd7)
                begin
                    r.byte_valid  = 1'b1;
                    r.rx_byte     = rx_sr;
                    r.byte_offset = byte_cnt[11:0];
                    bit_cnt       = '0;
                    byte_cnt      = byte_cnt + 1;
                    bytes_seen++;
                    // a shortened chunk_len ends the chunk at once
                    if (byte_cnt >= chunk_bytes())
                    begin
                        seq_phase = PH_READY;
                        chunks_seen++;
                    end
                end
                else
                begin
                    bit_cnt = bit_cnt + 5'd1;
                end
            end
        end
        r.chunk_base = cur_addr;
        r.status     = (seq_phase == PH_READY) ? ST_READY :
                       (seq_phase == PH_DONE)  ? ST_DONE  : ST_FILLING;
        return r;
    endfunction

    function automatic result_t bus_result(input logic c, input logic m, input logic s,
                                           input logic bv, input logic [7:0] b,
                                           input logic [11:0] off, input logic [23:0] a,
                                           input logic [1:0] st);
        result_t r;
        r.cs_n        = c;
        r.mosi        = m;
        r.sck_pulse   = s;
        r.byte_valid  = bv;
        r.rx_byte     = b;
        r.byte_offset = off;
        r.chunk_base  = a;
        r.status      = st;
        return r;
    endfunction

    // table builders
    function automatic void plan_items(input logic rq, input logic mb, input int reps);
        stim_row_t row;
        row       = '{kind: ROW_ITEM, default: '0};
        row.kind  = ROW_ITEM;
        row.rq    = rq;
        row.mb    = mb;
        row.reps  = reps;
        plan.push_back(row);
    endfunction

    function automatic void plan_typed(input logic rq, input logic mb, input result_t w);
        stim_row_t row;
        row       = '{kind: ROW_ITEM, default: '0};
        row.kind  = ROW_ITEM;
        row.rq    = rq;
        row.mb    = mb;
        row.reps  = 1;
        row.typed = 1'b1;
        row.want  = w;
        plan.push_back(row);
    endfunction

    function automatic void plan_write(input logic [2:0] a, input logic [31:0] d);
        stim_row_t row;
        row       = '{kind: ROW_WRITE, default: '0};
        row.kind  = ROW_WRITE;
        row.waddr = a;
        row.wdata = d;
        plan.push_back(row);
    endfunction

    task automatic flag_mismatch(input string msg);
        mismatches++;
        if (mismatches <= ERR_SHOW)
        begin
            $display("mismatch: %s", msg);
        end
    endtask

    // offer one item, with a random gap in front of it, and log its result once taken
    task automatic push_item(input logic rq, input logic mb, input bit typed,
                             input result_t want);
        int      gap;
        result_t got;
        if (idling_on && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 19);
            repeat (gap)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
            end
        end
        @(negedge clk);
        in_valid <= 1'b1;
        req_type <= rq;
        miso_bit <= mb;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        items_sent++;
        got = step_sequencer(rq, mb);
        pending_results.push_back(typed ? want : got);
    endtask

    // stop sending and let every owed result come out
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        @(posedge clk);
    endtask

    // register write while idle, then read it back
    task automatic write_reg(input logic [2:0] a, input logic [31:0] d);
        logic [31:0] rb;
        logic [31:0] want;
        drain();
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= a;
        pwdata  <= d;
        @(negedge clk);
        penable <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!pready);
        // straight into the read setup, psel stays high
        @(negedge clk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!pready);
        rb = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        reg_writes++;
        if (a[2] == REG_FLASH_END)
        begin
            cfg_flash_end = d[24:0];
            want          = {7'd0, d[24:0]};
        end
        else
        begin
            cfg_chunk_len = d[12:0];
            want          = {19'd0, d[12:0]};
        end
        if (rb !== want)
        begin
            flag_mismatch($sformatf("register at %0h read back %08h, wrote %08h", a, rb, want));
        end
    endtask

    // ------------------------------------------------------------------
    // result checker: every taken result against the oldest one owed
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        result_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                flag_mismatch($sformatf("unexpected result item cs_n=%b addr=%06h st=%0d",
                                        cs_n, chunk_base, status));
            end
            else
            begin
                e = pending_results.pop_front();
                if (cs_n !== e.cs_n || mosi !== e.mosi || sck_pulse !== e.sck_pulse ||
                    byte_valid !== e.byte_valid || rx_byte !== e.rx_byte ||
                    byte_offset !== e.byte_offset || chunk_base !== e.chunk_base ||
                    status !== e.status)
                begin
                    flag_mismatch({
                        $sformatf("result %0d exp cs_n=%b mosi=%b sck=%b bv=%b",
                                  results_seen, e.cs_n, e.mosi, e.sck_pulse,
                                  e.byte_valid),
                        $sformatf(" rx=%02h off=%0d addr=%06h st=%0d", e.rx_byte,
                                  e.byte_offset, e.chunk_base, e.status),
                        $sformatf(" | got cs_n=%b mosi=%b sck=%b bv=%b", cs_n, mosi,
                                  sck_pulse, byte_valid),
                        $sformatf(" rx=%02h off=%0d addr=%06h st=%0d", rx_byte,
                                  byte_offset, chunk_base, status)});
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still owed",
                     cycle_cnt, pending_results.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // receiver stall: random bursts, plus a long hold when one is asked for
    // ------------------------------------------------------------------
    initial
    begin : stall_gen
        int stall_left;
        stall_left = 0;
        out_stall  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                stall_left  = hold_cycles;
                hold_cycles = 0;
            end
            if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else
            begin
                out_stall <= 1'b0;
                if (idling_on && $urandom_range(0, 6) == 0)
                begin
                    stall_left = $urandom_range(1, 19);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin : main_seq
        int ph;
        int n;
        bit paused;
        bit end_by_start;
        result_t none;

        none     = '0;
        rst_n    = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        in_valid = 1'b0;
        req_type = REQ_TICK;
        miso_bit = 1'b0;
        reset_sequencer();

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed part, starting from the reset settings (2048 byte chunks)
        // clear while a chunk is still being filled is ignored
        plan_typed(REQ_CLEAR, 1'b0, bus_result(1'b1, 1'b0, 1'b0, 1'b0, 8'h00, 12'd0,
                                                24'd0, ST_FILLING));
        // first command bit of 0x03 is a zero
        plan_typed(REQ_TICK, 1'b0, bus_result(1'b0, 1'b0, 1'b1, 1'b0, 8'h00, 12'd0,
                                               24'd0, ST_FILLING));
        plan_items(REQ_TICK, 1'b1, 31);
        // all-ones and all-zeros data bytes
        plan_items(REQ_TICK, 1'b1, 7);
        plan_typed(REQ_TICK, 1'b1, bus_result(1'b0, 1'b1, 1'b1, 1'b1, 8'hFF, 12'd0,
                                               24'd0, ST_FILLING));
        plan_items(REQ_TICK, 1'b0, 7);
        plan_typed(REQ_TICK, 1'b0, bus_result(1'b0, 1'b1, 1'b1, 1'b1, 8'h00, 12'd1,
                                               24'd0, ST_FILLING));
        // shrink the chunk below the bytes already read: the next byte ends it
        plan_write({REG_CHUNK_LEN, 2'b00}, 32'd1);
        plan_items(REQ_TICK, 1'b0, 7);
        plan_typed(REQ_TICK, 1'b1, bus_result(1'b0, 1'b1, 1'b1, 1'b1, 8'h01, 12'd2,
                                               24'd0, ST_READY));
        // bit tick while the chunk waits for the host does nothing
        plan_typed(REQ_TICK, 1'b1, bus_result(1'b1, 1'b0, 1'b0, 1'b0, 8'h00, 12'd0,
                                               24'd0, ST_READY));
        // zero chunk length behaves as one byte; widest flash end
        plan_write({REG_CHUNK_LEN, 2'b00}, 32'd0);
        plan_write({REG_FLASH_END, 2'b00}, 32'h1000000);
        plan_typed(REQ_CLEAR, 1'b0, bus_result(1'b1, 1'b0, 1'b0, 1'b0, 8'h00, 12'd0,
                                                24'd1, ST_FILLING));
        plan_items(REQ_TICK, 1'b1, 1);
        plan_items(REQ_CLEAR, 1'b1, 1);
        plan_items(REQ_TICK, 1'b0, 39);
        // oversized chunk length clamps to 4096, then the exact maximum
        plan_write({REG_CHUNK_LEN, 2'b00}, 32'h1FFF);
        plan_items(REQ_CLEAR, 1'b0, 1);
        plan_items(REQ_TICK, 1'b1, 40);
        plan_write({REG_CHUNK_LEN, 2'b00}, 32'd4096);
        plan_items(REQ_TICK, 1'b0, 8);
        plan_write({REG_CHUNK_LEN, 2'b00}, 32'd3);
        plan_items(REQ_TICK, 1'b1, 8);
        plan_items(REQ_CLEAR, 1'b0, 1);

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_WRITE)
            begin
                write_reg(plan[i].waddr, plan[i].wdata);
            end
            else
            begin
                repeat (plan[i].reps)
                begin
                    push_item(plan[i].rq, plan[i].mb, plan[i].typed, plan[i].want);
                end
            end
        end

        // random part: short chunks with random miso data, a fresh setting each phase
        for (ph = 0; ph < RAND_PHASES; ph++)
        begin
            idling_on = (ph != 6);      // one phase runs flat out
            write_reg({REG_CHUNK_LEN, 2'b00}, (ph == 5) ? 32'd0 : $urandom_range(1, 5));
            write_reg({REG_FLASH_END, 2'b00}, $urandom_range(32'h10000, 32'h1000000));
            if (ph == 2)
            begin
                // long receiver hold while items keep coming: input side must back up
                hold_cycles = LONG_HOLD;
            end
            n      = 0;
            paused = 1'b0;
            while (n < PHASE_ITEMS)
            begin
                if (ph == 4 && n == PHASE_ITEMS / 2 && !paused)
                begin
                    // sender waits for every owed result mid-chunk
                    drain();
                    paused = 1'b1;
                end
                if (seq_phase == PH_READY)
                begin
                    if ($urandom_range(0, 4) == 0)
                    begin
                        push_item(REQ_TICK, 1'($urandom_range(0, 1)), 1'b0, none);
                    end
                    else
                    begin
                        push_item(REQ_CLEAR, 1'($urandom_range(0, 1)), 1'b0, none);
                        n++;
                    end
                end
                else if ($urandom_range(0, 19) == 0)
                begin
                    // stray clear in the middle of a chunk
                    push_item(REQ_CLEAR, 1'($urandom_range(0, 1)), 1'b0, none);
                end
                else
                begin
                    push_item(REQ_TICK, 1'($urandom_range(0, 1)), 1'b0, none);
                    n++;
                end
            end
        end

        // tail: no idling, run the chunk out and finish the dump
        idling_on = 1'b0;
        while (seq_phase != PH_READY)
        begin
            push_item(REQ_TICK, 1'($urandom_range(0, 1)), 1'b0, none);
        end
        end_by_start = 1'($urandom_range(0, 1));
        if (end_by_start)
        begin
            // next chunk starts, then the end is pulled below its address
            push_item(REQ_CLEAR, 1'b0, 1'b0, none);
            write_reg({REG_FLASH_END, 2'b00}, 32'd1);
            push_item(REQ_TICK, 1'b1, 1'b0, none);
        end
        else
        begin
            // smallest flash end: the clear finds the dump complete
            write_reg({REG_FLASH_END, 2'b00}, 32'd1);
            push_item(REQ_CLEAR, 1'b1, 1'b0, none);
        end
        // done is sticky: ticks and clears change nothing
        repeat (3) push_item(REQ_TICK, 1'($urandom_range(0, 1)), 1'b0, none);
        repeat (2) push_item(REQ_CLEAR, 1'($urandom_range(0, 1)), 1'b0, none);

        drain();
        repeat (3) @(posedge clk);

        $display("covered %0d items, %0d results, %0d data bytes over %0d chunks, %0d reg writes",
                 items_sent, results_seen, bytes_seen, chunks_seen, reg_writes);
        $display("dump ended by %s, %0d mismatches",
                 end_by_start ? "start past flash end" : "clear at flash end", mismatches);
        if (mismatches == 0 && pending_results.size() == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
